[design/matrix_multiply_core_assert.svh]
// Assertion macros for the matrix multiply core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define MATRIX_MULTIPLY_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MMC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix_multiply_core: check failed");

`define MMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix_multiply_core: check failed");

`else

`define MMC_ASSERT_IMP(label, clk, rst, ante, cons)

`define MMC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/mmc_pkg.sv]
// Types and constants shared by the matrix multiply core and its MAC cells.
// No dependencies.
package mmc_pkg;

   localparam int IDX_W  = 3;
   localparam int SIZE_W = 4;
   localparam int ELEM_W = 16;
   localparam int ACC_W  = 36;
   localparam int CSR_W  = 2;

   localparam logic [1:0] ACT_LOAD_A  = 2'd0;
   localparam logic [1:0] ACT_LOAD_B  = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   localparam logic [CSR_W-1:0] CSR_ROWS_OF_A  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [CSR_W-1:0] CSR_COLS_OF_B  = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   typedef struct packed {
      logic [1:0]              action;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [ELEM_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [ACC_W-1:0] out_value;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic [IDX_W-1:0] k;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size_value,
                                                  input logic [SIZE_W-1:0] max_dim);
      logic [SIZE_W-1:0] result;
      if (size_value == '0) begin
         result = 4'd1;
      end else if (size_value > max_dim) begin
         result = max_dim;
      end else begin
         result = size_value;
      end
      return result;
   endfunction

endpackage

[design/mmc_cell.sv]
// One MAC cell of the chain: holds one column of B and one accumulator.
// Passes the A element and its control token to the next cell each cycle. Uses mmc_pkg.
module mmc_cell #(
   parameter int DATA_WIDTH = 16,
   parameter int MAX_DIM    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic signed [DATA_WIDTH-1:0]    a_in,
   input  mmc_pkg::cell_ctl_type           ctl_in,
   output logic signed [DATA_WIDTH-1:0]    a_out,
   output mmc_pkg::cell_ctl_type           ctl_out,
   input  logic                            b_we,
   input  logic [$clog2(MAX_DIM)-1:0]      b_row,
   input  logic signed [DATA_WIDTH-1:0]    b_data,
   output logic signed [mmc_pkg::ACC_W-1:0] acc
);

   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int PROD_W = 2 * DATA_WIDTH;

   logic signed [DATA_WIDTH-1:0]     b_col_ff [MAX_DIM];
   logic signed [DATA_WIDTH-1:0]     b_sel;
   logic signed [PROD_W-1:0]         prod;
   logic signed [mmc_pkg::ACC_W-1:0] acc_ff;
   logic signed [mmc_pkg::ACC_W-1:0] acc_in;
   logic signed [DATA_WIDTH-1:0]     a_ff;
   mmc_pkg::cell_ctl_type            ctl_ff;

   assign b_sel = b_col_ff[ctl_in.k[DIM_W-1:0]];
   assign prod  = a_in * b_sel;

   always_comb begin
      if (ctl_in.first) begin
         acc_in = mmc_pkg::ACC_W'(prod);
      end else begin
         acc_in = acc_ff + mmc_pkg::ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      if (ctl_in.valid) begin
         acc_ff <= acc_in;
      end
      if (b_we) begin
         b_col_ff[b_row] <= b_data;
      end
   end

   assign a_out   = a_ff;
   assign ctl_out = ctl_ff;
   assign acc     = acc_ff;

endmodule

[design/matrix_multiply_core.sv]
// Matrix multiply core: C = A x B over a chain of MAC cells, one per column.
// Depends on mmc_pkg, mmc_cell and matrix_multiply_core_assert.svh.
//
//   channel | ports                        | direction | beat
//   --------+------------------------------+-----------+------------------------------
//   req     | req_valid req_ready req_data | in        | load A, load B or compute
//   rsp     | rsp_valid rsp_ready rsp_data | out       | one element of C
//   csr     | csr_valid csr_ready csr_index| in        | size register write
//           | csr_data                     |           |
//
// A load beat is taken while idle. A compute beat, for each row of C, streams
// row i of A through the cell chain, lets the chain drain, and hands out the
// row through the single output register, req_ready low meanwhile. The A and B
// stores get no clearing pass after reset. rsp_ready low stalls only the
// hand-out of results; csr writes are always taken.
module matrix_multiply_core #(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  mmc_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mmc_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mmc_pkg::CSR_W-1:0]    csr_index,
   input  logic [mmc_pkg::SIZE_W-1:0]   csr_data
);

`include "matrix_multiply_core_assert.svh"

   localparam int DIM_W   = $clog2(MAX_DIM);
   localparam int A_DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW      = $clog2(A_DEPTH);
   localparam logic [mmc_pkg::SIZE_W-1:0] MAX_SIZE = mmc_pkg::SIZE_W'(MAX_DIM);
   localparam logic [DIM_W-1:0] DRAIN_END = DIM_W'(MAX_DIM - 1);

   logic [mmc_pkg::SIZE_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [mmc_pkg::SIZE_W-1:0] n_eff, m_eff, p_eff;

   mmc_pkg::state_type state_ff, state_in;
   logic [DIM_W-1:0]   i_ff, j_ff, k_ff, drain_ff;
   logic               i_last, j_last, k_last;

   logic req_fire, compute_start, load_a_ok, load_b_ok;
   logic feed, emit_load;

   logic signed [DATA_WIDTH-1:0] elem;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic signed [DATA_WIDTH-1:0] a_mem [A_DEPTH];
   logic signed [DATA_WIDTH-1:0] a_rd_ff;
   mmc_pkg::cell_ctl_type        inj_ctl_ff;

   logic signed [DATA_WIDTH-1:0]     a_chain   [MAX_DIM+1];
   mmc_pkg::cell_ctl_type            ctl_chain [MAX_DIM+1];
   logic signed [mmc_pkg::ACC_W-1:0] acc_vec   [MAX_DIM];
   logic [MAX_DIM-1:0]               b_we;

   logic             rsp_valid_ff;
   mmc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mmc_pkg::SIZE_RESET;
         inner_ff <= mmc_pkg::SIZE_RESET;
         cols_ff  <= mmc_pkg::SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mmc_pkg::CSR_ROWS_OF_A:  rows_ff  <= csr_data;
            mmc_pkg::CSR_INNER_SIZE: inner_ff <= csr_data;
            mmc_pkg::CSR_COLS_OF_B:  cols_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign n_eff = mmc_pkg::eff_size(rows_ff, MAX_SIZE);
   assign m_eff = mmc_pkg::eff_size(inner_ff, MAX_SIZE);
   assign p_eff = mmc_pkg::eff_size(cols_ff, MAX_SIZE);

   // request decode
   assign req_fire      = req_valid && req_ready;
   assign compute_start = req_fire && (req_data.action == mmc_pkg::ACT_COMPUTE);
   assign load_a_ok     = req_fire && (req_data.action == mmc_pkg::ACT_LOAD_A)
                          && ({1'b0, req_data.row_index} < n_eff)
                          && ({1'b0, req_data.col_index} < m_eff);
   assign load_b_ok     = req_fire && (req_data.action == mmc_pkg::ACT_LOAD_B)
                          && ({1'b0, req_data.row_index} < m_eff)
                          && ({1'b0, req_data.col_index} < p_eff);

   assign elem = DATA_WIDTH'($unsigned(req_data.element_value));

   assign i_last = (mmc_pkg::SIZE_W'(i_ff) + 4'd1) == n_eff;
   assign j_last = (mmc_pkg::SIZE_W'(j_ff) + 4'd1) == p_eff;
   assign k_last = (mmc_pkg::SIZE_W'(k_ff) + 4'd1) == m_eff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mmc_pkg::ST_IDLE: begin
            if (compute_start) begin
               state_in = mmc_pkg::ST_FEED;
            end
         end
         mmc_pkg::ST_FEED: begin
            if (k_last) begin
               state_in = mmc_pkg::ST_DRAIN;
            end
         end
         mmc_pkg::ST_DRAIN: begin
            if (drain_ff == DRAIN_END) begin
               state_in = mmc_pkg::ST_EMIT;
            end
         end
         mmc_pkg::ST_EMIT: begin
            if (emit_load && j_last) begin
               state_in = i_last ? mmc_pkg::ST_IDLE : mmc_pkg::ST_FEED;
            end
         end
         default: state_in = mmc_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      feed      = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         mmc_pkg::ST_IDLE:  req_ready = 1'b1;
         mmc_pkg::ST_FEED:  feed      = 1'b1;
         mmc_pkg::ST_DRAIN: ;
         mmc_pkg::ST_EMIT:  emit_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmc_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (compute_start) begin
            i_ff <= '0;
            k_ff <= '0;
         end
         if (feed) begin
            k_ff     <= k_last ? '0 : k_ff + 1'b1;
            drain_ff <= '0;
         end
         if (state_ff == mmc_pkg::ST_DRAIN) begin
            drain_ff <= drain_ff + 1'b1;
            j_ff     <= '0;
         end
         if (emit_load) begin
            j_ff <= j_ff + 1'b1;
            if (j_last) begin
               i_ff <= i_ff + 1'b1;
               k_ff <= '0;
            end
         end
      end
   end

   // A store
   assign wr_addr = AW'(req_data.row_index[DIM_W-1:0]) * AW'(MAX_DIM)
                    + AW'(req_data.col_index[DIM_W-1:0]);
   assign rd_addr = AW'(i_ff) * AW'(MAX_DIM) + AW'(k_ff);

   always_ff @(posedge clock) begin
      if (load_a_ok) begin
         a_mem[wr_addr] <= elem;
      end
      a_rd_ff <= a_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inj_ctl_ff <= '0;
      end else begin
         inj_ctl_ff.valid <= feed;
         inj_ctl_ff.first <= (k_ff == '0);
         inj_ctl_ff.k     <= mmc_pkg::IDX_W'(k_ff);
      end
   end

   // cell chain
   assign a_chain[0]   = a_rd_ff;
   assign ctl_chain[0] = inj_ctl_ff;

   for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
      assign b_we[c] = load_b_ok && (req_data.col_index == mmc_pkg::IDX_W'(c));

      mmc_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .MAX_DIM    (MAX_DIM)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .a_in    (a_chain[c]),
         .ctl_in  (ctl_chain[c]),
         .a_out   (a_chain[c+1]),
         .ctl_out (ctl_chain[c+1]),
         .b_we    (b_we[c]),
         .b_row   (req_data.row_index[DIM_W-1:0]),
         .b_data  (elem),
         .acc     (acc_vec[c])
      );
   end

   // output register
   always_comb begin
      rsp_data_in.out_row   = mmc_pkg::IDX_W'(i_ff);
      rsp_data_in.out_col   = mmc_pkg::IDX_W'(j_ff);
      rsp_data_in.out_value = acc_vec[j_ff];
      rsp_data_in.last      = i_last && j_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `MMC_ASSERT_NEXT(a_last_ends_run, clock, reset, emit_load && rsp_data_in.last, state_ff == mmc_pkg::ST_IDLE)
   `MMC_ASSERT_IMP(a_chain_drained, clock, reset, state_ff == mmc_pkg::ST_EMIT, !ctl_chain[MAX_DIM-1].valid)
   `MMC_ASSERT_IMP(a_idle_only_last, clock, reset, rsp_valid_ff && !rsp_data_ff.last, state_ff != mmc_pkg::ST_IDLE)

endmodule
